/* rtl/core/xzc_pkg.sv */
// ----------------------------------------------------------------------------
// xzc_pkg
// Shared types, constants and a CRC byte helper for the XZ container checker.
// ----------------------------------------------------------------------------
package xzc_pkg;

   localparam int MAX_VARINT_BYTES_DEF = 9;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
   localparam logic [31:0] HDR_PRESET = 32'h2DFD1072;

   localparam logic [7:0] FILTER_LZMA2 = 8'h21;
   localparam logic [7:0] FOOTER_Y     = 8'h59;
   localparam logic [7:0] FOOTER_Z     = 8'h5A;

   localparam logic [4:0] ST_OK          = 5'd0;
   localparam logic [4:0] ST_END         = 5'd1;
   localparam logic [4:0] ST_HDR_MAGIC   = 5'd2;
   localparam logic [4:0] ST_HDR_CHECK   = 5'd3;
   localparam logic [4:0] ST_HDR_CRC     = 5'd4;
   localparam logic [4:0] ST_BLK_FLAGS   = 5'd5;
   localparam logic [4:0] ST_FILTER_ID   = 5'd6;
   localparam logic [4:0] ST_PROP_SIZE   = 5'd7;
   localparam logic [4:0] ST_PROP        = 5'd8;
   localparam logic [4:0] ST_PADDING     = 5'd9;
   localparam logic [4:0] ST_BHDR_CRC    = 5'd10;
   localparam logic [4:0] ST_CSIZE       = 5'd11;
   localparam logic [4:0] ST_USIZE       = 5'd12;
   localparam logic [4:0] ST_BLK_CHECK   = 5'd13;
   localparam logic [4:0] ST_IDX_COUNT   = 5'd14;
   localparam logic [4:0] ST_IDX_HASH    = 5'd15;
   localparam logic [4:0] ST_IDX_PAD     = 5'd16;
   localparam logic [4:0] ST_IDX_CRC     = 5'd17;
   localparam logic [4:0] ST_FTR_FLAGS   = 5'd18;
   localparam logic [4:0] ST_FTR_MAGIC   = 5'd19;
   localparam logic [4:0] ST_FTR_CRC     = 5'd20;
   localparam logic [4:0] ST_LZMA_BASE   = 5'd21;

   localparam logic [2:0] KIND_CONT  = 3'd0;
   localparam logic [2:0] KIND_COMP  = 3'd1;
   localparam logic [2:0] KIND_UNC   = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_ERR   = 3'd4;

   typedef enum logic [3:0] {
      PH_HEADER, PH_BOI, PH_BLOCK, PH_INDEX, PH_FOOTER, PH_END
   } phase_type;

   typedef enum logic [3:0] {
      BS_FLAGS, BS_CSIZE, BS_USIZE, BS_FID, BS_PSIZE, BS_PROP,
      BS_PAD, BS_HCRC, BS_DATA, BS_BPAD, BS_CHECK
   } bsub_type;

   typedef enum logic [2:0] {
      IS_COUNT, IS_UNPAD, IS_UNCOMP, IS_PAD, IS_CRC
   } isub_type;

   typedef enum logic [1:0] {
      CS_IDLE, CS_STEP, CS_HASH, CS_OUT
   } ctl_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [1:0] lzma2_error_code;
   } req_type;

   typedef struct packed {
      logic [4:0] status;
      logic       dict_reset;
      logic [5:0] dict_bits;
      logic       in_block_data;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic step;   // run the item step
      logic hash;   // one record-hash byte
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hash_busy;
   } sts_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

endpackage

/* rtl/core/xzc_ctrl.sv */
// ----------------------------------------------------------------------------
// xzc_ctrl
// Handshake sequencer: accept, step, drain record hash, present result.
// ----------------------------------------------------------------------------
module xzc_ctrl
   import xzc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_STEP;
         end
         CS_STEP: state_in = sts.hash_busy ? CS_HASH : CS_OUT;
         CS_HASH: begin
            if (!sts.hash_busy) state_in = CS_OUT;
         end
         CS_OUT: begin
            if (rsp_ready) state_in = req_valid ? CS_STEP : CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         CS_IDLE: req_ready = 1'b1;
         CS_STEP: cmd.step = 1'b1;
         CS_HASH: cmd.hash = 1'b1;
         CS_OUT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/xzc_datapath.sv */
// ----------------------------------------------------------------------------
// xzc_datapath
// Container state, CRC units, size counters and record hash serializer.
// ----------------------------------------------------------------------------
module xzc_datapath
   import xzc_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_take,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   req_type     item_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  sub_ff, sub_in;
   logic [10:0] pos_ff, pos_in;
   logic        crc_chk_ff, crc_chk_in;
   logic [7:0]  flags_ff, flags_in;
   logic [10:0] hlen_ff, hlen_in;
   logic [3:0]  vcnt_ff, vcnt_in;
   logic [63:0] vval_ff, vval_in;
   logic [63:0] dcomp_ff, dcomp_in, duncomp_ff, duncomp_in;
   logic [63:0] ccomp_ff, ccomp_in, cuncomp_ff, cuncomp_in;
   logic [31:0] rcrc_ff, rcrc_in, dcrc_ff, dcrc_in;
   logic [31:0] bhash_ff, bhash_in, ihash_ff, ihash_in;
   logic [63:0] bcount_ff, bcount_in, rleft_ff, rleft_in;
   logic [31:0] fcrc_ff, fcrc_in;
   logic [4:0]  err_ff, err_in;
   logic [5:0]  dbits_ff, dbits_in;
   logic        pulse_ff, pulse_in;
   logic [4:0]  code_ff, code_in;
   // record hash serializer: up to 16 bytes into block or index hash
   logic [127:0] hq_ff, hq_in;
   logic [4:0]   hn_ff, hn_in;
   logic         hsel_ff, hsel_in;   // 1 = index hash

   // bytes still queued after this cycle's step or hash byte
   assign sts.hash_busy = (hn_in != 5'd0);

   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; sub_ff <= '0; pos_ff <= '0; crc_chk_ff <= 1'b0;
         flags_ff <= '0; hlen_ff <= '0; vcnt_ff <= '0; vval_ff <= '0;
         dcomp_ff <= '0; duncomp_ff <= '0; ccomp_ff <= '0; cuncomp_ff <= '0;
         rcrc_ff <= CRC_INIT; dcrc_ff <= CRC_INIT; bhash_ff <= CRC_INIT;
         ihash_ff <= CRC_INIT; bcount_ff <= '0; rleft_ff <= '0; fcrc_ff <= '0;
         err_ff <= '0; dbits_ff <= '0; pulse_ff <= 1'b0; code_ff <= '0;
         hn_ff <= '0; hsel_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; sub_ff <= sub_in; pos_ff <= pos_in;
         crc_chk_ff <= crc_chk_in; flags_ff <= flags_in; hlen_ff <= hlen_in;
         vcnt_ff <= vcnt_in; vval_ff <= vval_in; dcomp_ff <= dcomp_in;
         duncomp_ff <= duncomp_in; ccomp_ff <= ccomp_in; cuncomp_ff <= cuncomp_in;
         rcrc_ff <= rcrc_in; dcrc_ff <= dcrc_in; bhash_ff <= bhash_in;
         ihash_ff <= ihash_in; bcount_ff <= bcount_in; rleft_ff <= rleft_in;
         fcrc_ff <= fcrc_in; err_ff <= err_in; dbits_ff <= dbits_in;
         pulse_ff <= pulse_in; code_ff <= code_in; hn_ff <= hn_in;
         hsel_ff <= hsel_in;
      end
   end

   always_ff @(posedge clock) begin
      hq_ff <= hq_in;
   end

   // one varint byte: returns done, updates acc and count
   function automatic logic [68:0] vtake(input logic [63:0] acc, input logic [3:0] cnt,
                                         input logic [7:0] b);
      logic [6:0]  sh;
      logic [63:0] a;
      logic [3:0]  c;
      logic        done;
      sh = 7'(cnt) * 7'd7;
      a  = acc;
      if (sh < 7'd64) a = acc | ({57'd0, b[6:0]} << sh[5:0]);
      c    = cnt + 4'd1;
      done = !b[7] || (5'(c) >= 5'(MAX_VARINT_BYTES));
      return {done, c, a};
   endfunction

   logic [31:0] crc_b;          // running crc stepped by item byte
   logic [31:0] hcrc_out;
   logic [7:0]  b;
   logic [2:0]  kind;
   logic [10:0] body_end;
   logic [68:0] vt;
   logic [63:0] unpadded;
   logic [1:0]  hsh;
   logic [10:0] pos_p1;

   assign b        = item_ff.data_byte;
   assign kind     = item_ff.kind;
   assign crc_b    = crc_byte(rcrc_ff, b);
   assign hcrc_out = crc_byte(hsel_ff ? ihash_ff : bhash_ff, hq_ff[7:0]);
   assign body_end = hlen_ff - 11'd4;
   assign pos_p1   = pos_ff + 11'd1;

   always_comb begin
      phase_in = phase_ff; sub_in = sub_ff; pos_in = pos_ff; crc_chk_in = crc_chk_ff;
      flags_in = flags_ff; hlen_in = hlen_ff; vcnt_in = vcnt_ff; vval_in = vval_ff;
      dcomp_in = dcomp_ff; duncomp_in = duncomp_ff; ccomp_in = ccomp_ff;
      cuncomp_in = cuncomp_ff; rcrc_in = rcrc_ff; dcrc_in = dcrc_ff;
      bhash_in = bhash_ff; ihash_in = ihash_ff; bcount_in = bcount_ff;
      rleft_in = rleft_ff; fcrc_in = fcrc_ff; err_in = err_ff; dbits_in = dbits_ff;
      pulse_in = pulse_ff; code_in = code_ff; hq_in = hq_ff; hn_in = hn_ff;
      hsel_in = hsel_ff;
      vt = '0; unpadded = '0; hsh = '0;

      if (cmd.hash) begin
         if (hsel_ff) ihash_in = hcrc_out;
         else         bhash_in = hcrc_out;
         hq_in = hq_ff >> 8;
         hn_in = hn_ff - 5'd1;
         // index settle deferred until its record hash completes
         if (hsel_ff && hn_ff == 5'd1 && sub_ff == 4'(IS_UNPAD) && rleft_ff == '0) begin
            ihash_in = ~hcrc_out;
            if (~hcrc_out != bhash_ff) begin
               code_in = ST_IDX_HASH; err_in = ST_IDX_HASH;
            end else begin
               sub_in = 4'(IS_PAD);
               if (pos_ff[1:0] == 2'd0) begin
                  sub_in = 4'(IS_CRC); pos_in = '0; rcrc_in = ~rcrc_ff;
               end
            end
         end
      end

      if (cmd.step) begin
         pulse_in = 1'b0;
         code_in  = ST_OK;
         if (err_ff != '0) begin
            code_in = err_ff;
         end else if (phase_ff == 4'(PH_END)) begin
            code_in = ST_END;
         end else if (kind == KIND_CONT) begin
            unique case (phase_ff)
               4'(PH_HEADER): begin
                  if (pos_ff < 11'd6) begin
                     case (pos_ff[2:0])
                        3'd0: if (b != 8'hFD) code_in = ST_HDR_MAGIC;
                        3'd1: if (b != 8'h37) code_in = ST_HDR_MAGIC;
                        3'd2: if (b != 8'h7A) code_in = ST_HDR_MAGIC;
                        3'd3: if (b != 8'h58) code_in = ST_HDR_MAGIC;
                        3'd4: if (b != 8'h5A) code_in = ST_HDR_MAGIC;
                        default: if (b != 8'h00) code_in = ST_HDR_MAGIC;
                     endcase
                  end else if (pos_ff == 11'd6) begin
                     if (b != 8'h00) code_in = ST_HDR_CHECK;
                  end else if (pos_ff == 11'd7) begin
                     if (b > 8'd1) code_in = ST_HDR_CHECK;
                     else begin
                        crc_chk_in = b[0];
                        rcrc_in = ~crc_byte(HDR_PRESET, b);
                     end
                  end else begin
                     hsh = 2'(pos_ff - 11'd8);
                     if (b != 8'(rcrc_ff >> {hsh, 3'b000})) code_in = ST_HDR_CRC;
                  end
                  if (code_in == ST_OK) begin
                     pos_in = pos_p1;
                     if (pos_p1 >= 11'd12) begin
                        phase_in = 4'(PH_BOI); pos_in = '0; bcount_in = '0;
                        bhash_in = CRC_INIT;
                     end
                  end
               end
               4'(PH_BOI): begin
                  if (b != 8'd0) begin
                     phase_in = 4'(PH_BLOCK); sub_in = 4'(BS_FLAGS);
                     rcrc_in = crc_byte(CRC_INIT, b);
                     hlen_in = {1'b0, b, 2'b00} + 11'd4;
                     ccomp_in = '0; cuncomp_in = '0;
                  end else begin
                     phase_in = 4'(PH_INDEX); sub_in = 4'(IS_COUNT);
                     vcnt_in = '0; vval_in = '0; bhash_in = ~bhash_ff;
                     rcrc_in = crc_byte(CRC_INIT, 8'd0); ihash_in = CRC_INIT;
                  end
                  pos_in = 11'd1;
               end
               4'(PH_BLOCK): begin
                  if (sub_ff <= 4'(BS_PROP) && pos_ff >= body_end) begin
                     code_in = ST_BLK_FLAGS;
                  end else begin
                     logic adv;
                     logic hdr_crc;
                     adv = 1'b1; hdr_crc = 1'b0;
                     case (sub_ff)
                        4'(BS_FLAGS): begin
                           if (b[5:0] != '0) begin code_in = ST_BLK_FLAGS; adv = 1'b0; end
                           else begin
                              flags_in = b;
                              if (b[7:6] == 2'b00) sub_in = 4'(BS_FID);
                              else if (b[7:6] == 2'b10) sub_in = 4'(BS_USIZE);
                              else sub_in = 4'(BS_CSIZE);
                              vcnt_in = '0; dcomp_in = '0; duncomp_in = '0;
                           end
                        end
                        4'(BS_CSIZE): begin
                           vt = vtake(dcomp_ff, vcnt_ff, b);
                           dcomp_in = vt[63:0]; vcnt_in = vt[67:64];
                           if (vt[68]) begin
                              vcnt_in = '0;
                              sub_in = flags_ff[7] ? 4'(BS_USIZE) : 4'(BS_FID);
                           end
                        end
                        4'(BS_USIZE): begin
                           vt = vtake(duncomp_ff, vcnt_ff, b);
                           duncomp_in = vt[63:0]; vcnt_in = vt[67:64];
                           if (vt[68]) begin vcnt_in = '0; sub_in = 4'(BS_FID); end
                        end
                        4'(BS_FID): begin
                           if (b != FILTER_LZMA2) begin code_in = ST_FILTER_ID; adv = 1'b0; end
                           else sub_in = 4'(BS_PSIZE);
                        end
                        4'(BS_PSIZE): begin
                           if (b != 8'h01) begin code_in = ST_PROP_SIZE; adv = 1'b0; end
                           else sub_in = 4'(BS_PROP);
                        end
                        4'(BS_PROP): begin
                           if (b[7:6] != 2'b00) begin code_in = ST_PROP; adv = 1'b0; end
                           else begin dbits_in = b[5:0]; sub_in = 4'(BS_PAD); end
                        end
                        4'(BS_PAD): begin
                           if (pos_ff < body_end) begin
                              if (b != 8'd0) code_in = ST_PADDING;
                              adv = (b == 8'd0);
                           end else begin
                              sub_in = 4'(BS_HCRC); hdr_crc = 1'b1; adv = 1'b0;
                           end
                        end
                        4'(BS_HCRC): begin hdr_crc = 1'b1; adv = 1'b0; end
                        4'(BS_BPAD): begin
                           adv = 1'b0;
                           if (b != 8'd0) code_in = ST_PADDING;
                           else begin
                              pos_in = pos_p1;
                              if (pos_p1[1:0] == 2'd0) begin
                                 unpadded = 64'(hlen_ff) + ccomp_ff +
                                            (crc_chk_ff ? 64'd4 : 64'd0);
                                 bcount_in = bcount_ff + 64'd1;
                                 hq_in = {cuncomp_ff, unpadded}; hn_in = 5'd16;
                                 hsel_in = 1'b0; pos_in = '0;
                                 if (crc_chk_ff) sub_in = 4'(BS_CHECK);
                                 else phase_in = 4'(PH_BOI);
                              end
                           end
                        end
                        4'(BS_CHECK): begin
                           adv = 1'b0;
                           if (b != 8'(dcrc_ff >> {pos_ff[1:0], 3'b000}))
                              code_in = ST_BLK_CHECK;
                           else begin
                              pos_in = pos_p1;
                              if (pos_p1 >= 11'd4) begin
                                 phase_in = 4'(PH_BOI); pos_in = '0;
                              end
                           end
                        end
                        default: adv = 1'b0;
                     endcase
                     if (hdr_crc) begin
                        logic [31:0] hc;
                        hc = (sub_ff == 4'(BS_PAD)) ? ~rcrc_ff : rcrc_ff;
                        rcrc_in = hc;
                        hsh = 2'(hlen_ff - pos_ff - 11'd1) ^ 2'd3;
                        if (b != 8'(hc >> {hsh, 3'b000})) code_in = ST_BHDR_CRC;
                        else begin
                           pos_in = pos_p1;
                           if (pos_p1 >= hlen_ff) begin
                              sub_in = 4'(BS_DATA); dcrc_in = CRC_INIT; pulse_in = 1'b1;
                           end
                        end
                     end
                     if (adv) begin
                        rcrc_in = crc_b; pos_in = pos_p1;
                     end
                  end
               end
               4'(PH_INDEX): begin
                  if (sub_ff == 4'(IS_CRC)) begin
                     if (b != 8'(rcrc_ff >> {pos_ff[1:0], 3'b000})) code_in = ST_IDX_CRC;
                     else begin
                        pos_in = pos_p1;
                        if (pos_p1 >= 11'd4) begin
                           phase_in = 4'(PH_FOOTER); pos_in = '0; fcrc_in = '0;
                           rcrc_in = CRC_INIT;
                        end
                     end
                  end else if (sub_ff == 4'(IS_PAD) && b != 8'd0) begin
                     code_in = ST_IDX_PAD;
                  end else begin
                     logic settle;
                     logic [31:0] rc;
                     settle = 1'b1;
                     rc = crc_b;
                     rcrc_in = crc_b; pos_in = pos_p1;
                     if (sub_ff == 4'(IS_COUNT)) begin
                        vt = vtake(vval_ff, vcnt_ff, b);
                        vval_in = vt[63:0]; vcnt_in = vt[67:64];
                        if (vt[68]) begin
                           if (vt[63:0] != bcount_ff) begin
                              code_in = ST_IDX_COUNT; settle = 1'b0;
                           end else begin
                              rleft_in = vt[63:0]; vval_in = '0; vcnt_in = '0;
                              sub_in = 4'(IS_UNPAD);
                           end
                        end
                     end else if (sub_ff == 4'(IS_UNPAD) || sub_ff == 4'(IS_UNCOMP)) begin
                        vt = vtake(vval_ff, vcnt_ff, b);
                        vval_in = vt[63:0]; vcnt_in = vt[67:64];
                        if (vt[68]) begin
                           hq_in = {64'd0, vt[63:0]}; hn_in = 5'd8; hsel_in = 1'b1;
                           vval_in = '0; vcnt_in = '0;
                           if (sub_ff == 4'(IS_UNCOMP)) begin
                              rleft_in = rleft_ff - 64'd1; sub_in = 4'(IS_UNPAD);
                           end else begin
                              sub_in = 4'(IS_UNCOMP);
                           end
                           settle = 1'b0;  // settled after hash drain
                        end
                     end
                     if (settle) begin
                        if (sub_in == 4'(IS_UNPAD) && rleft_in == '0) begin
                           ihash_in = ~ihash_ff;
                           if (~ihash_ff != bhash_ff) code_in = ST_IDX_HASH;
                           else begin
                              sub_in = 4'(IS_PAD);
                              if (pos_p1[1:0] == 2'd0) begin
                                 sub_in = 4'(IS_CRC); pos_in = '0; rcrc_in = ~rc;
                              end
                           end
                        end else if (sub_in == 4'(IS_PAD) && pos_p1[1:0] == 2'd0) begin
                           sub_in = 4'(IS_CRC); pos_in = '0; rcrc_in = ~rc;
                        end
                     end
                  end
               end
               4'(PH_FOOTER): begin
                  if (pos_ff < 11'd4) begin
                     fcrc_in = fcrc_ff | ({24'd0, b} << {pos_ff[1:0], 3'b000});
                     pos_in = pos_p1;
                  end else if (pos_ff < 11'd8) begin
                     rcrc_in = crc_b; pos_in = pos_p1;
                  end else if (pos_ff == 11'd8 || pos_ff == 11'd9) begin
                     if (b != ((pos_ff == 11'd8) ? 8'd0 : {7'd0, crc_chk_ff}))
                        code_in = ST_FTR_FLAGS;
                     else begin rcrc_in = crc_b; pos_in = pos_p1; end
                  end else if (pos_ff == 11'd10) begin
                     if (b != FOOTER_Y) code_in = ST_FTR_MAGIC;
                     else pos_in = pos_p1;
                  end else begin
                     if (b != FOOTER_Z) code_in = ST_FTR_MAGIC;
                     else if (fcrc_ff != ~rcrc_ff) code_in = ST_FTR_CRC;
                     else begin phase_in = 4'(PH_END); code_in = ST_END; end
                  end
               end
               default: ;
            endcase
         end else if (kind <= KIND_ERR) begin
            if (phase_ff == 4'(PH_BLOCK) && sub_ff == 4'(BS_DATA)) begin
               case (kind)
                  KIND_COMP: ccomp_in = ccomp_ff + 64'd1;
                  KIND_UNC: begin
                     cuncomp_in = cuncomp_ff + 64'd1;
                     if (crc_chk_ff) dcrc_in = crc_byte(dcrc_ff, b);
                  end
                  KIND_ERR: code_in = ST_LZMA_BASE + {3'd0, item_ff.lzma2_error_code};
                  default: begin
                     if (flags_ff[6] && dcomp_ff != ccomp_ff) code_in = ST_CSIZE;
                     else if (flags_ff[7] && duncomp_ff != cuncomp_ff) code_in = ST_USIZE;
                     else begin
                        if (crc_chk_ff) dcrc_in = ~dcrc_ff;
                        sub_in = 4'(BS_BPAD);
                        pos_in = {9'd0, ccomp_ff[1:0]};
                        if (ccomp_ff[1:0] == 2'd0) begin
                           unpadded = 64'(hlen_ff) + ccomp_ff +
                                      (crc_chk_ff ? 64'd4 : 64'd0);
                           bcount_in = bcount_ff + 64'd1;
                           hq_in = {cuncomp_ff, unpadded}; hn_in = 5'd16;
                           hsel_in = 1'b0; pos_in = '0;
                           if (crc_chk_ff) sub_in = 4'(BS_CHECK);
                           else phase_in = 4'(PH_BOI);
                        end
                     end
                  end
               endcase
            end
         end
         if (err_ff == '0 && code_in >= 5'd2) begin
            err_in = code_in; pulse_in = 1'b0;
            hn_in = '0;
         end
      end
   end

   assign rsp_data.status        = code_ff;
   assign rsp_data.dict_reset    = pulse_ff;
   assign rsp_data.dict_bits     = dbits_ff;
   assign rsp_data.in_block_data = (err_ff == '0) && (phase_ff == 4'(PH_BLOCK)) &&
                                   (sub_ff == 4'(BS_DATA));

endmodule

/* rtl/core/xz_container_checker_core.sv */
// ----------------------------------------------------------------------------
// xz_container_checker_core
// Byte-serial XZ container checker with external LZMA2 event inputs.
// ----------------------------------------------------------------------------
// Each accepted item is applied in the step state, then its response is
// presented. At block end a 16-byte record, and after each index size field
// an 8-byte value, is first folded into the record hash one byte per cycle
// through a single CRC byte unit. New items wait until the response is taken.
// Reset: synchronous, active high; returns to the stream header, no error.
module xz_container_checker_core
   import xzc_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // controller sequences each transfer; datapath holds all container state
   xzc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .sts
   );

   xzc_datapath #(.MAX_VARINT_BYTES(MAX_VARINT_BYTES)) u_dp (
      .clock, .reset,
      .req_take (req_valid && req_ready),
      .req_data, .cmd, .sts, .rsp_data
   );

endmodule

/* rtl/core/xzc_checker.sv */
// ----------------------------------------------------------------------------
// xzc_checker
// Port-level properties of the container checker.
// ----------------------------------------------------------------------------
module xzc_checker
   import xzc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.status >= 5'd2 |=> !rsp_data.in_block_data)
      else $error("block data still flagged after error");

   a_pulse_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dict_reset |-> rsp_data.status == ST_OK &&
      rsp_data.in_block_data)
      else $error("dictionary reset without entering block data");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready || rsp_ready)
      else $error("input ready while response pending");

endmodule

bind xz_container_checker_core xzc_checker u_xzc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);

/* bench/tb_xz_container_checker_core.sv */
// ----------------------------------------------------------------------------
// tb_xz_container_checker_core
// Streams one XZ container through the checker: stream header, directed and
// random LZMA2 blocks with noise items, index and footer (or a failing block),
// then items after the end. A cycle-free model of the checker predicts every
// response, and responses are compared field by field in transfer order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xz_container_checker_core;
   import xzc_pkg::*;

   localparam logic [7:0] PROP_SIZE_ONE = 8'h01;
   localparam int         RANDOM_ITEMS  = 900;
   localparam int         STALL_CYCLES  = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   xz_container_checker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // --------------------------------------------------------------------------
   // Checker model state (one response per item)
   // --------------------------------------------------------------------------
   phase_type   ph;
   bsub_type    bsub;
   isub_type    isub;
   logic [10:0] pos, hlen;
   logic [3:0]  vcnt;
   logic        check_crc;
   logic [7:0]  bflags;
   logic [63:0] vval, dcomp, duncomp, ccomp, cuncomp, nblocks, recs_left;
   logic [31:0] run_crc, dat_crc, blk_hash, idx_hash, ftr_crc;
   logic [4:0]  err;
   logic [5:0]  dbits;
   logic        pulse;

   localparam logic [7:0] STREAM_MAGIC [6] = '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00};

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      sent_items = 0;

   // idle percentages and long-stall request
   int send_idle = 0;
   int recv_idle = 0;
   int stall_requests = 0;
   int stall_seen = 0;
   int stall_left = 0;

   // stream builder state
   logic [7:0]  build_q[$];
   logic [63:0] rec_unpad[$], rec_unc[$];
   logic        gen_check;
   logic        gen_in_data = 1'b0;
   int          noise_pct = 0;
   logic        force_long = 1'b0;

   function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
         r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      return r;
   endfunction

   function automatic logic [31:0] crc_qword(input logic [31:0] c, input logic [63:0] v);
      for (int i = 0; i < 8; i++)
         c = crc_fold(c, v[8*i +: 8]);
      return c;
   endfunction

   function automatic void model_reset();
      ph = PH_HEADER; bsub = BS_FLAGS; isub = IS_COUNT;
      pos = '0; hlen = '0; vcnt = '0; check_crc = 1'b0; bflags = '0;
      vval = '0; dcomp = '0; duncomp = '0; ccomp = '0; cuncomp = '0;
      nblocks = '0; recs_left = '0;
      run_crc = CRC_INIT; dat_crc = CRC_INIT; blk_hash = CRC_INIT; idx_hash = CRC_INIT;
      ftr_crc = '0; err = '0; dbits = '0; pulse = 1'b0;
   endfunction

   // 7-bit groups, little end first; ends on a clear top bit or the byte limit
   function automatic bit absorb_varint(inout logic [63:0] acc, input logic [7:0] b);
      int sh;
      sh = int'(vcnt) * 7;
      if (sh < 64)
         acc |= {57'd0, b[6:0]} << sh;
      vcnt = vcnt + 4'd1;
      return !b[7] || vcnt >= MAX_VARINT_BYTES_DEF;
   endfunction

   function automatic logic [4:0] stream_header_byte(input logic [7:0] b);
      if (pos < 6) begin
         if (b != STREAM_MAGIC[pos]) return ST_HDR_MAGIC;
      end else if (pos == 6) begin
         if (b != 0) return ST_HDR_CHECK;
      end else if (pos == 7) begin
         if (b > 1) return ST_HDR_CHECK;
         check_crc = b[0];
         run_crc = ~crc_fold(HDR_PRESET, b);
      end else begin
         if (b != run_crc[8 * ((pos - 11'd8) & 11'd3) +: 8]) return ST_HDR_CRC;
      end
      pos = pos + 11'd1;
      if (pos >= 12) begin
         ph = PH_BOI;
         pos = '0;
         nblocks = '0;
         blk_hash = CRC_INIT;
      end
      return ST_OK;
   endfunction

   function automatic void block_or_index(input logic [7:0] b);
      if (b != 0) begin
         ph = PH_BLOCK;
         bsub = BS_FLAGS;
         run_crc = crc_fold(CRC_INIT, b);
         hlen = ({3'd0, b} + 11'd1) * 11'd4;
         ccomp = '0;
         cuncomp = '0;
      end else begin
         ph = PH_INDEX;
         isub = IS_COUNT;
         vcnt = '0;
         vval = '0;
         blk_hash = ~blk_hash;
         run_crc = crc_fold(CRC_INIT, 8'h00);
         idx_hash = CRC_INIT;
      end
      pos = 11'd1;
   endfunction

   // a finished block adds its record to the hash the index must reproduce
   function automatic void close_block();
      logic [63:0] unpadded;
      unpadded = {53'd0, hlen} + ccomp + (check_crc ? 64'd4 : 64'd0);
      nblocks = nblocks + 64'd1;
      blk_hash = crc_qword(crc_qword(blk_hash, unpadded), cuncomp);
      pos = '0;
      if (check_crc) bsub = BS_CHECK;
      else ph = PH_BOI;
   endfunction

   function automatic logic [4:0] header_crc_byte(input logic [7:0] b);
      logic [10:0] t;
      t = hlen - pos - 11'd1;
      if (b != run_crc[8 * (t[1:0] ^ 2'd3) +: 8]) return ST_BHDR_CRC;
      pos = pos + 11'd1;
      if (pos >= hlen) begin
         bsub = BS_DATA;
         dat_crc = CRC_INIT;
         pulse = 1'b1;
      end
      return ST_OK;
   endfunction

   function automatic logic [4:0] block_byte(input logic [7:0] b);
      logic [10:0] body_end;
      body_end = hlen - 11'd4;
      // header fields may not run into the four CRC bytes
      if (bsub <= BS_PROP && pos >= body_end) return ST_BLK_FLAGS;
      case (bsub)
         BS_FLAGS: begin
            if (b[5:0] != 0) return ST_BLK_FLAGS;
            bflags = b;
            if (b[7:6] == 2'b00) bsub = BS_FID;
            else if (b[7:6] == 2'b10) bsub = BS_USIZE;
            else bsub = BS_CSIZE;
            vcnt = '0;
            dcomp = '0;
            duncomp = '0;
         end
         BS_CSIZE: begin
            if (absorb_varint(dcomp, b)) begin
               vcnt = '0;
               bsub = bflags[7] ? BS_USIZE : BS_FID;
            end
         end
         BS_USIZE: begin
            if (absorb_varint(duncomp, b)) begin
               vcnt = '0;
               bsub = BS_FID;
            end
         end
         BS_FID: begin
            if (b != FILTER_LZMA2) return ST_FILTER_ID;
            bsub = BS_PSIZE;
         end
         BS_PSIZE: begin
            if (b != PROP_SIZE_ONE) return ST_PROP_SIZE;
            bsub = BS_PROP;
         end
         BS_PROP: begin
            if (b[7:6] != 0) return ST_PROP;
            dbits = b[5:0];
            bsub = BS_PAD;
         end
         BS_PAD: begin
            // already aligned: this byte is the first CRC byte
            if (pos < body_end) begin
               if (b != 0) return ST_PADDING;
            end else begin
               bsub = BS_HCRC;
               run_crc = ~run_crc;
               return header_crc_byte(b);
            end
         end
         BS_HCRC: return header_crc_byte(b);
         BS_BPAD: begin
            if (b != 0) return ST_PADDING;
            pos = pos + 11'd1;
            if (pos[1:0] == 2'd0) close_block();
            return ST_OK;
         end
         BS_CHECK: begin
            if (b != dat_crc[8 * pos[1:0] +: 8]) return ST_BLK_CHECK;
            pos = pos + 11'd1;
            if (pos >= 4) begin
               ph = PH_BOI;
               pos = '0;
            end
            return ST_OK;
         end
         default: return ST_OK;
      endcase
      run_crc = crc_fold(run_crc, b);
      pos = pos + 11'd1;
      return ST_OK;
   endfunction

   function automatic logic [4:0] lzma_event(input logic [2:0] kind, input logic [7:0] b,
                                             input logic [1:0] ec);
      if (ph != PH_BLOCK || bsub != BS_DATA) return ST_OK;
      if (kind == KIND_COMP) begin
         ccomp = ccomp + 64'd1;
      end else if (kind == KIND_UNC) begin
         cuncomp = cuncomp + 64'd1;
         if (check_crc) dat_crc = crc_fold(dat_crc, b);
      end else if (kind == KIND_ERR) begin
         return ST_LZMA_BASE + {3'd0, ec};
      end else begin
         if (bflags[6] && dcomp != ccomp) return ST_CSIZE;
         if (bflags[7] && duncomp != cuncomp) return ST_USIZE;
         if (check_crc) dat_crc = ~dat_crc;
         bsub = BS_BPAD;
         pos = {9'd0, ccomp[1:0]};
         if (pos == 0) close_block();
      end
      return ST_OK;
   endfunction

   function automatic logic [4:0] index_settle();
      if (isub == IS_UNPAD && recs_left == 0) begin
         idx_hash = ~idx_hash;
         if (idx_hash != blk_hash) return ST_IDX_HASH;
         isub = IS_PAD;
      end
      if (isub == IS_PAD && pos[1:0] == 2'd0) begin
         isub = IS_CRC;
         pos = '0;
         run_crc = ~run_crc;
      end
      return ST_OK;
   endfunction

   function automatic logic [4:0] index_byte(input logic [7:0] b);
      if (isub == IS_CRC) begin
         if (b != run_crc[8 * pos[1:0] +: 8]) return ST_IDX_CRC;
         pos = pos + 11'd1;
         if (pos >= 4) begin
            ph = PH_FOOTER;
            pos = '0;
            ftr_crc = '0;
            run_crc = CRC_INIT;
         end
         return ST_OK;
      end
      if (isub == IS_PAD && b != 0) return ST_IDX_PAD;
      run_crc = crc_fold(run_crc, b);
      pos = pos + 11'd1;
      if (isub == IS_COUNT) begin
         if (absorb_varint(vval, b)) begin
            if (vval != nblocks) return ST_IDX_COUNT;
            recs_left = vval;
            vval = '0;
            vcnt = '0;
            isub = IS_UNPAD;
         end
      end else if (isub == IS_UNPAD || isub == IS_UNCOMP) begin
         if (absorb_varint(vval, b)) begin
            idx_hash = crc_qword(idx_hash, vval);
            vval = '0;
            vcnt = '0;
            if (isub == IS_UNCOMP) begin
               recs_left = recs_left - 64'd1;
               isub = IS_UNPAD;
            end else begin
               isub = IS_UNCOMP;
            end
         end
      end
      return index_settle();
   endfunction

   function automatic logic [4:0] footer_byte(input logic [7:0] b);
      if (pos < 4) begin
         ftr_crc |= {24'd0, b} << (8 * pos);
      end else if (pos < 8) begin
         run_crc = crc_fold(run_crc, b);
      end else if (pos == 8 || pos == 9) begin
         if (b != ((pos == 8) ? 8'd0 : {7'd0, check_crc})) return ST_FTR_FLAGS;
         run_crc = crc_fold(run_crc, b);
      end else if (pos == 10) begin
         if (b != FOOTER_Y) return ST_FTR_MAGIC;
      end else begin
         if (b != FOOTER_Z) return ST_FTR_MAGIC;
         if (ftr_crc != ~run_crc) return ST_FTR_CRC;
         ph = PH_END;
         return ST_END;
      end
      pos = pos + 11'd1;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_response(input req_type it);
      rsp_type r;
      logic [4:0] code;
      code = ST_OK;
      pulse = 1'b0;
      if (err != 0) begin
         code = err;
      end else if (ph == PH_END) begin
         code = ST_END;
      end else begin
         if (it.kind == KIND_CONT) begin
            case (ph)
               PH_HEADER: code = stream_header_byte(it.data_byte);
               PH_BOI:    block_or_index(it.data_byte);
               PH_BLOCK:  code = block_byte(it.data_byte);
               PH_INDEX:  code = index_byte(it.data_byte);
               PH_FOOTER: code = footer_byte(it.data_byte);
               default: ;
            endcase
         end else if (it.kind <= KIND_ERR) begin
            code = lzma_event(it.kind, it.data_byte, it.lzma2_error_code);
         end
         if (code >= ST_HDR_MAGIC) begin
            err = code;
            pulse = 1'b0;
         end
      end
      r.status = code;
      r.dict_reset = pulse;
      r.dict_bits = dbits;
      r.in_block_data = (err == 0) && ph == PH_BLOCK && bsub == BS_DATA;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Response side: random ready, long stalls on request, in-order compare
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_requests != stall_seen) begin
            stall_seen <= stall_requests;
            stall_left <= STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_data.status, -1);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.dict_reset !== want.dict_reset)
                  report_mismatch("dict_reset", rsp_data.dict_reset, want.dict_reset);
               if (rsp_data.dict_bits !== want.dict_bits)
                  report_mismatch("dict_bits", rsp_data.dict_bits, want.dict_bits);
               if (rsp_data.in_block_data !== want.in_block_data)
                  report_mismatch("in_block_data", rsp_data.in_block_data, want.in_block_data);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------
   task automatic send_item(input logic [2:0] kind, input logic [7:0] b, input logic [1:0] ec);
      req_type it;
      it.kind = kind;
      it.data_byte = b;
      it.lzma2_error_code = ec;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_response(it));
      sent_items++;
   endtask

   // items the checker must ignore in the current phase
   task automatic maybe_noise();
      logic [2:0] k;
      if ($urandom_range(99) < noise_pct) begin
         if (gen_in_data) k = ($urandom_range(1) == 0) ? KIND_CONT : 3'($urandom_range(5, 7));
         else k = 3'($urandom_range(1, 7));
         send_item(k, 8'($urandom), 2'($urandom));
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      maybe_noise();
      send_item(KIND_CONT, b, 2'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // varint, sometimes stretched with empty continuation groups
   function automatic void push_varint(input logic [63:0] v);
      int n0, n;
      logic [7:0] b;
      n0 = 1;
      while (n0 < 9 && (v >> (7 * n0)) != 0) n0++;
      n = (force_long || $urandom_range(4) == 0) ? $urandom_range(9, n0) : n0;
      if (force_long) n = 9;
      for (int i = 0; i < n; i++) begin
         b = {(i < n - 1), v[7*i +: 7]};
         if (i == 8 && $urandom_range(1) == 0) b[7] = 1'b1;
         build_q.push_back(b);
      end
   endfunction

   function automatic logic [31:0] crc_of_build();
      logic [31:0] c;
      c = CRC_INIT;
      foreach (build_q[i]) c = crc_fold(c, build_q[i]);
      return ~c;
   endfunction

   task automatic send_build_with_crc();
      logic [31:0] c;
      c = crc_of_build();
      for (int i = 0; i < 4; i++) build_q.push_back(c[8*i +: 8]);
      foreach (build_q[i]) send_byte(build_q[i]);
      build_q.delete();
   endtask

   task automatic send_block(input logic [1:0] sizes, input int ncomp, input int nunc,
                             input logic [5:0] dict, input int extra_words,
                             input bit lzma_fail);
      int total, ci, ui;
      logic [31:0] dcrc;
      logic [7:0] b;
      build_q.delete();
      build_q.push_back(8'h00);
      build_q.push_back({sizes, 6'd0});
      if (sizes[0]) push_varint(64'(ncomp));
      if (sizes[1]) push_varint(64'(nunc));
      build_q.push_back(FILTER_LZMA2);
      build_q.push_back(PROP_SIZE_ONE);
      build_q.push_back({2'b00, dict});
      total = ((build_q.size() + 4 + 3) / 4) * 4 + 4 * extra_words;
      build_q[0] = 8'(total / 4 - 1);
      while (build_q.size() < total - 4) build_q.push_back(8'h00);
      send_build_with_crc();
      gen_in_data = 1'b1;
      dcrc = CRC_INIT;
      ci = 0;
      ui = 0;
      while (ci < ncomp || ui < nunc) begin
         maybe_noise();
         b = 8'($urandom);
         if (ui >= nunc || (ci < ncomp && $urandom_range(1) == 0)) begin
            send_item(KIND_COMP, b, 2'($urandom));
            ci++;
         end else begin
            send_item(KIND_UNC, b, 2'($urandom));
            dcrc = crc_fold(dcrc, b);
            ui++;
         end
      end
      if (lzma_fail) begin
         send_item(KIND_ERR, 8'($urandom), 2'($urandom));
         gen_in_data = 1'b0;
         return;
      end
      send_item(KIND_END, 8'($urandom), 2'($urandom));
      gen_in_data = 1'b0;
      for (int i = 0; i < (4 - ncomp % 4) % 4; i++) send_byte(8'h00);
      if (gen_check)
         for (int i = 0; i < 4; i++) send_byte(~dcrc[8*i +: 8]);
      rec_unpad.push_back(64'(total + ncomp + (gen_check ? 4 : 0)));
      rec_unc.push_back(64'(nunc));
   endtask

   task automatic random_block();
      int nc, nu;
      nc = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 9);
      nu = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 9);
      send_block(2'($urandom), nc, nu, 6'($urandom),
                 ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   task automatic test_stream_header();
      logic [31:0] c;
      logic [7:0] chk;
      send_item(3'd5, 8'hFF, 2'd3);
      send_item(KIND_UNC, 8'hA5, 2'd0);
      send_item(KIND_ERR, 8'h00, 2'd2);
      chk = 8'($urandom_range(1));
      gen_check = chk[0];
      c = ~crc_fold(HDR_PRESET, chk);
      foreach (STREAM_MAGIC[i]) send_byte(STREAM_MAGIC[i]);
      send_byte(8'h00);
      send_byte(chk);
      for (int i = 0; i < 4; i++) send_byte(c[8*i +: 8]);
   endtask

   task automatic test_directed_blocks();
      // both sizes as full-length varints, aligned data, largest dictionary code
      force_long = 1'b1;
      send_block(2'b11, 4, 2, 6'd63, 0, 1'b0);
      force_long = 1'b0;
      // no sizes, unaligned data, extra header padding, smallest code
      send_block(2'b00, 3, 0, 6'd0, 1, 1'b0);
      // uncompressed size only, empty data
      send_block(2'b10, 0, 0, 6'd21, 0, 1'b0);
   endtask

   task automatic test_random_blocks();
      int start, leg;
      start = sent_items;
      noise_pct = 8;
      leg = 0;
      send_idle = 38;
      recv_idle = 87;
      while (sent_items - start < RANDOM_ITEMS) begin
         random_block();
         if (leg == 0 && sent_items - start > RANDOM_ITEMS / 6) begin
            // receiver holds off while the sender keeps offering items
            stall_requests++;
            leg = 1;
         end else if (leg == 1 && sent_items - start > RANDOM_ITEMS / 3) begin
            drain_results();
            send_idle = 87;
            recv_idle = 38;
            leg = 2;
         end else if (leg == 2 && sent_items - start > 2 * RANDOM_ITEMS / 3) begin
            send_idle = 0;
            recv_idle = 0;
            leg = 3;
         end
      end
      noise_pct = 0;
   endtask

   task automatic test_index_footer();
      int mode;
      logic [31:0] c;
      logic [7:0] tail[$];
      mode = $urandom_range(3);
      if (mode == 2) begin
         send_block(2'b01, 5, 5, 6'($urandom), 0, 1'b1);
         return;
      end
      build_q.delete();
      build_q.push_back(8'h00);
      push_varint(64'(rec_unpad.size()));
      foreach (rec_unpad[i]) begin
         // a wrong record must break the record hash
         push_varint((mode == 3 && i == 0) ? rec_unpad[i] + 64'd4 : rec_unpad[i]);
         push_varint(rec_unc[i]);
      end
      while (build_q.size() % 4 != 0) build_q.push_back(8'h00);
      send_build_with_crc();
      for (int i = 0; i < 4; i++) tail.push_back(8'($urandom));
      tail.push_back(8'h00);
      tail.push_back({7'd0, gen_check});
      c = CRC_INIT;
      foreach (tail[i]) c = crc_fold(c, tail[i]);
      c = ~c;
      if (mode == 1) c[0] = ~c[0];
      for (int i = 0; i < 4; i++) send_byte(c[8*i +: 8]);
      foreach (tail[i]) send_byte(tail[i]);
      send_byte(FOOTER_Y);
      send_byte(FOOTER_Z);
   endtask

   task automatic test_after_end();
      for (int i = 0; i < 8; i++)
         send_item(3'($urandom), 8'($urandom), 2'($urandom));
   endtask

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_stream_header();
      test_directed_blocks();
      test_random_blocks();
      test_index_footer();
      test_after_end();
      drain_results();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
